// ===== rtl/core/kdds_pkg.sv =====
// kdds_pkg: shared widths, register codes, reset values, beat types and the
// seven-segment code table for the keypad setpoint core.
// No dependencies; compile first.
package kdds_pkg;

    localparam int KEY_COUNT  = 4;
    localparam int HOLD_W     = 3;
    localparam int THR_W      = 3;
    localparam int SP_W       = 10;
    localparam int STEP_W     = 7;
    localparam int DUTY_W     = 8;
    localparam int SEG_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // Event bit positions
    localparam int KEY_UP_FINE     = 0;
    localparam int KEY_DOWN_FINE   = 1;
    localparam int KEY_UP_COARSE   = 2;
    localparam int KEY_DOWN_COARSE = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_THRESHOLD = 2'd0,
        REG_SETPOINT_MAX       = 2'd1,
        REG_COARSE_STEP        = 2'd2
    } cfg_reg_t;

    localparam logic [HOLD_W-1:0] HOLD_MAX       = 3'd7;
    localparam logic [THR_W-1:0]  THR_RESET      = 3'd5;
    localparam logic [SP_W-1:0]   SP_MAX_RESET   = 10'd999;
    localparam logic [STEP_W-1:0] STEP_RESET     = 7'd10;
    localparam logic [SP_W-1:0]   SETPOINT_RESET = 10'd1;
    localparam logic [SEG_W-1:0]  SEG_POINT_MASK = 8'h7F;
    localparam logic [SEG_W-1:0]  SEG_BLANK      = 8'hFF;

    typedef struct packed {
        logic [SP_W-1:0]      setpoint;
        logic [KEY_COUNT-1:0] events;
    } sp_beat_t;

    typedef struct packed {
        logic [SP_W-1:0]      setpoint_out;
        logic [DUTY_W-1:0]    pwm_duty;
        logic [SEG_W-1:0]     seg_hundreds;
        logic [SEG_W-1:0]     seg_tens;
        logic [SEG_W-1:0]     seg_units;
        logic [KEY_COUNT-1:0] press_events;
    } disp_beat_t;

    // Active-low segments, bit 7 is the decimal point (off)
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/kdds_key_if.sv =====
// kdds_key_if: valid/ready channel carrying one key-scan beat.
// No dependencies.
interface kdds_key_if;
    logic valid;
    logic ready;
    logic key_up_fine;
    logic key_down_fine;
    logic key_up_coarse;
    logic key_down_coarse;

    modport source (
        output valid, key_up_fine, key_down_fine, key_up_coarse, key_down_coarse,
        input  ready
    );
    modport sink (
        input  valid, key_up_fine, key_down_fine, key_up_coarse, key_down_coarse,
        output ready
    );
endinterface

// ===== rtl/core/kdds_disp_if.sv =====
// kdds_disp_if: valid/ready channel carrying one display/result beat.
// No dependencies.
interface kdds_disp_if;
    logic       valid;
    logic       ready;
    logic [9:0] setpoint_out;
    logic [7:0] pwm_duty;
    logic [7:0] seg_hundreds;
    logic [7:0] seg_tens;
    logic [7:0] seg_units;
    logic [3:0] press_events;

    modport source (
        output valid, setpoint_out, pwm_duty, seg_hundreds, seg_tens, seg_units,
               press_events,
        input  ready
    );
    modport sink (
        input  valid, setpoint_out, pwm_duty, seg_hundreds, seg_tens, seg_units,
               press_events,
        output ready
    );
endinterface

// ===== rtl/core/kdds_readout.sv =====
// kdds_readout: two-stage pipeline that splits the setpoint into decimal
// digits and builds segment codes and PWM duty. Depends on kdds_pkg.
module kdds_readout
    import kdds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sp_beat_t   in_beat,
    output logic       out_valid,
    input  logic       out_ready,
    output disp_beat_t out_beat
);

    logic                 b_valid_reg;
    logic [SP_W-1:0]      b_setpoint_reg;
    logic [KEY_COUNT-1:0] b_events_reg;
    logic [3:0]           b_hund_reg;
    logic [6:0]           b_rem_reg;

    logic                 c_valid_reg;
    disp_beat_t           c_beat_reg;

    logic                 c_free;
    logic                 b_free;
    logic [3:0]           hund_count;
    logic [SP_W-1:0]      hund_base;
    logic [3:0]           hund_next;
    logic [6:0]           rem_next;
    logic [3:0]           tens_digit;
    logic [6:0]           tens_base;
    logic [3:0]           units_digit;
    disp_beat_t           c_beat_next;

    assign c_free   = !c_valid_reg || out_ready;
    assign b_free   = !b_valid_reg || c_free;
    assign in_ready = b_free;

    // Hundreds by parallel compares against multiples of 100
    always_comb
    begin
        hund_count = 4'd0;
        hund_base  = '0;
        for (int k = 1; k <= 10; k++)
        begin
            if (in_beat.setpoint >= SP_W'(k * 100))
            begin
                hund_count = 4'(k);
                hund_base  = SP_W'(k * 100);
            end
        end
        // setpoints of 1000 and above wrap the display
        hund_next = (hund_count == 4'd10) ? 4'd0 : hund_count;
        rem_next  = 7'(in_beat.setpoint - hund_base);
    end

    always_comb
    begin
        tens_digit = 4'd0;
        tens_base  = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (b_rem_reg >= 7'(k * 10))
            begin
                tens_digit = 4'(k);
                tens_base  = 7'(k * 10);
            end
        end
        units_digit = 4'(b_rem_reg - tens_base);

        c_beat_next.setpoint_out = b_setpoint_reg;
        c_beat_next.pwm_duty     = b_setpoint_reg[SP_W-1 -: DUTY_W];
        c_beat_next.seg_hundreds = seg_code(b_hund_reg);
        c_beat_next.seg_tens     = seg_code(tens_digit) & SEG_POINT_MASK;
        c_beat_next.seg_units    = seg_code(units_digit);
        c_beat_next.press_events = b_events_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && in_valid)
        begin
            b_setpoint_reg <= in_beat.setpoint;
            b_events_reg   <= in_beat.events;
            b_hund_reg     <= hund_next;
            b_rem_reg      <= rem_next;
        end
        if (c_free && b_valid_reg)
        begin
            c_beat_reg <= c_beat_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_beat  = c_beat_reg;

endmodule

// ===== rtl/core/keypad_debounced_duty_setpoint_core.sv =====
// keypad_debounced_duty_setpoint_core: top level. Key debounce, setpoint
// update, config registers. Depends on kdds_pkg, kdds_key_if, kdds_disp_if,
// kdds_readout.
//
// One key-scan beat per clock cycle is accepted while key.ready is high.
// Each gives exactly one display beat. The setpoint stage loads at the
// accepting edge, then the digit split stage, then the segment/output
// stage. The rate is set by the setpoint update: one saturating add and
// one saturating subtract feed the setpoint register, which the next beat
// reads. Debounce counters, latches and the setpoint advance only on an
// accepted beat. Config writes (cfg_we, cfg_index, cfg_data) take effect
// on the next beat; index 3 is ignored. Output backpressure stalls the
// pipeline; key.ready drops only when all three stages hold beats that
// are not taken.
module keypad_debounced_duty_setpoint_core
    import kdds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    kdds_key_if.sink               key,
    kdds_disp_if.source            disp
);

    logic [THR_W-1:0]  thr_reg;
    logic [SP_W-1:0]   sp_max_reg;
    logic [STEP_W-1:0] step_reg;

    logic [HOLD_W-1:0]    hold_reg    [KEY_COUNT];
    logic [HOLD_W-1:0]    hold_next   [KEY_COUNT];
    logic [KEY_COUNT-1:0] latched_reg;
    logic [KEY_COUNT-1:0] latched_next;
    logic [SP_W-1:0]      setpoint_reg;
    logic [SP_W-1:0]      setpoint_next;

    logic                 a_valid_reg;
    sp_beat_t             a_beat_reg;

    logic                 key_acc;
    logic                 ro_ready;
    logic [KEY_COUNT-1:0] keys_held;
    logic [KEY_COUNT-1:0] ev;
    logic [STEP_W:0]      up_amt;
    logic [STEP_W:0]      dn_amt;
    logic [SP_W:0]        up_sum;
    logic [SP_W-1:0]      sp_up;
    logic                 ro_out_valid;
    disp_beat_t           ro_out_beat;

    assign key.ready = !a_valid_reg || ro_ready;
    assign key_acc   = key.valid && key.ready;
    assign keys_held = {key.key_down_coarse, key.key_up_coarse,
                        key.key_down_fine, key.key_up_fine};

    always_comb
    begin
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            hold_next[i]    = hold_reg[i];
            latched_next[i] = latched_reg[i];
            ev[i]           = 1'b0;
            if (keys_held[i])
            begin
                if (!latched_reg[i])
                begin
                    if (hold_reg[i] != HOLD_MAX)
                    begin
                        hold_next[i] = hold_reg[i] + 3'd1;
                    end
                    if (hold_next[i] > thr_reg)
                    begin
                        latched_next[i] = 1'b1;
                        ev[i]           = 1'b1;
                    end
                end
            end
            else
            begin
                hold_next[i]    = '0;
                latched_next[i] = 1'b0;
            end
        end
    end

    // Chained saturations collapse: min(v + a, max) then max(v - b, 0)
    always_comb
    begin
        up_amt = (ev[KEY_UP_FINE] ? (STEP_W+1)'(1) : '0)
               + (ev[KEY_UP_COARSE] ? {1'b0, step_reg} : '0);
        dn_amt = (ev[KEY_DOWN_FINE] ? (STEP_W+1)'(1) : '0)
               + (ev[KEY_DOWN_COARSE] ? {1'b0, step_reg} : '0);
        up_sum = {1'b0, setpoint_reg} + (SP_W+1)'(up_amt);

        if (ev[KEY_UP_FINE] || ev[KEY_UP_COARSE])
        begin
            sp_up = (up_sum < {1'b0, sp_max_reg}) ? up_sum[SP_W-1:0] : sp_max_reg;
        end
        else
        begin
            sp_up = setpoint_reg;
        end

        if (sp_up > SP_W'(dn_amt))
        begin
            setpoint_next = sp_up - SP_W'(dn_amt);
        end
        else
        begin
            setpoint_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_RESET;
            sp_max_reg   <= SP_MAX_RESET;
            step_reg     <= STEP_RESET;
            latched_reg  <= '0;
            setpoint_reg <= SETPOINT_RESET;
            a_valid_reg  <= 1'b0;
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                    REG_SETPOINT_MAX:       sp_max_reg <= cfg_data[SP_W-1:0];
                    REG_COARSE_STEP:        step_reg   <= cfg_data[STEP_W-1:0];
                    default:                ;
                endcase
            end
            if (key_acc)
            begin
                latched_reg  <= latched_next;
                setpoint_reg <= setpoint_next;
                for (int i = 0; i < KEY_COUNT; i++)
                begin
                    hold_reg[i] <= hold_next[i];
                end
            end
            if (key.ready)
            begin
                a_valid_reg <= key.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_acc)
        begin
            a_beat_reg.setpoint <= setpoint_next;
            a_beat_reg.events   <= ev;
        end
    end

    kdds_readout u_readout (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_ready  (ro_ready),
        .in_beat   (a_beat_reg),
        .out_valid (ro_out_valid),
        .out_ready (disp.ready),
        .out_beat  (ro_out_beat)
    );

    assign disp.valid        = ro_out_valid;
    assign disp.setpoint_out = ro_out_beat.setpoint_out;
    assign disp.pwm_duty     = ro_out_beat.pwm_duty;
    assign disp.seg_hundreds = ro_out_beat.seg_hundreds;
    assign disp.seg_tens     = ro_out_beat.seg_tens;
    assign disp.seg_units    = ro_out_beat.seg_units;
    assign disp.press_events = ro_out_beat.press_events;

`ifndef ASSERT_OFF
    a_setpoint_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !key_acc |=> $stable(setpoint_reg))
        else $error("setpoint changed without an accepted key beat");

    a_event_latches_key: assert property (@(posedge clk) disable iff (!rst_n)
        key_acc |=> ((latched_reg & $past(ev)) == $past(ev)))
        else $error("press event did not latch its key");

    a_increment_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        key_acc && (ev[KEY_UP_FINE] || ev[KEY_UP_COARSE]) && (dn_amt == '0)
        |=> setpoint_reg <= $past(sp_max_reg))
        else $error("increment left setpoint above its limit");
`endif

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for keypad_debounced_duty_setpoint_core.
// Drives key-scan beats and register writes, predicts each display beat and
// compares it with the core's output. Depends on kdds_pkg and both channel ifs.
`timescale 1ns / 100ps

module testbench;
    import kdds_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;   // unused index, write ignored
    localparam int DRAIN_CYCLES = 6;
    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    kdds_key_if  key_ch ();
    kdds_disp_if disp_ch ();

    keypad_debounced_duty_setpoint_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key_ch),
        .disp      (disp_ch)
    );

    // predictor state and register copies
    logic [HOLD_W-1:0]    hold_cnt [KEY_COUNT];
    logic                 latched  [KEY_COUNT];
    logic [SP_W-1:0]      setpoint = SETPOINT_RESET;
    logic [THR_W-1:0]     thr_reg  = THR_RESET;
    logic [SP_W-1:0]      max_reg  = SP_MAX_RESET;
    logic [STEP_W-1:0]    step_reg = STEP_RESET;

    disp_beat_t pending_readouts [$];
    int         mismatches = 0;
    bit         src_gaps_on = 1'b1;
    bit         sink_gaps_on = 1'b1;
    int         sink_hold = 0;

    initial begin
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            hold_cnt[i] = '0;
            latched[i]  = 1'b0;
        end
    end

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic disp_beat_t predict_scan(input logic [KEY_COUNT-1:0] keys);
        disp_beat_t           beat;
        logic [KEY_COUNT-1:0] ev;
        int                   sp;
        int                   i;
        ev = '0;
        for (i = 0; i < KEY_COUNT; i++)
        begin
            if (keys[i])
            begin
                if (!latched[i])
                begin
                    if (hold_cnt[i] != HOLD_MAX)
                        hold_cnt[i] = hold_cnt[i] + 1'b1;
                    if (hold_cnt[i] > thr_reg)
                    begin
                        latched[i] = 1'b1;
                        ev[i] = 1'b1;
                    end
                end
            end
            else
            begin
                hold_cnt[i] = '0;
                latched[i]  = 1'b0;
            end
        end
        sp = setpoint;
        // increments clamp to max, even from above it
        if (ev[KEY_UP_FINE])
            sp = (sp + 1 < max_reg) ? sp + 1 : max_reg;
        if (ev[KEY_UP_COARSE])
            sp = (sp + step_reg < max_reg) ? sp + step_reg : max_reg;
        if (ev[KEY_DOWN_FINE])
            sp = (sp > 1) ? sp - 1 : 0;
        if (ev[KEY_DOWN_COARSE])
            sp = (sp > step_reg) ? sp - step_reg : 0;
        setpoint = sp[SP_W-1:0];

        beat.setpoint_out = setpoint;
        beat.pwm_duty     = setpoint[SP_W-1:2];
        beat.seg_hundreds = DIGIT_SEGS[(sp / 100) % 10];
        beat.seg_tens     = DIGIT_SEGS[(sp / 10) % 10] & SEG_POINT_MASK;
        beat.seg_units    = DIGIT_SEGS[sp % 10];
        beat.press_events = ev;
        return beat;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name,
                         want_v, got_v);
        end
    endtask

    // scoreboard: check outgoing beat first, then record the incoming scan and any register write
    always @(posedge clk)
    begin : scoreboard
        disp_beat_t want;
        if (rst_n)
        begin
            if (disp_ch.valid && disp_ch.ready)
            begin
                if (pending_readouts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: display beat with nothing expected", $realtime);
                end
                else
                begin
                    want = pending_readouts.pop_front();
                    check_field("setpoint_out", want.setpoint_out, disp_ch.setpoint_out);
                    check_field("pwm_duty", want.pwm_duty, disp_ch.pwm_duty);
                    check_field("seg_hundreds", want.seg_hundreds, disp_ch.seg_hundreds);
                    check_field("seg_tens", want.seg_tens, disp_ch.seg_tens);
                    check_field("seg_units", want.seg_units, disp_ch.seg_units);
                    check_field("press_events", want.press_events, disp_ch.press_events);
                end
            end
            if (key_ch.valid && key_ch.ready)
                pending_readouts.push_back(predict_scan({key_ch.key_down_coarse,
                    key_ch.key_up_coarse, key_ch.key_down_fine, key_ch.key_up_fine}));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE_THRESHOLD: thr_reg  = cfg_data[THR_W-1:0];
                    REG_SETPOINT_MAX:       max_reg  = cfg_data[SP_W-1:0];
                    REG_COARSE_STEP:        step_reg = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // display sink: random stalls, plus a counted hold-off on request
    initial
    begin : display_sink
        int n;
        disp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold != 0)
            begin
                disp_ch.ready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            else if (sink_gaps_on && $urandom_range(0, 3) == 0)
            begin
                disp_ch.ready <= 1'b0;
                n = gap_len();
                repeat (n) @(posedge clk);
            end
            else
                disp_ch.ready <= 1'b1;
        end
    end

    // valid stays high after a beat so back-to-back scans never toggle it in one step
    task automatic send_scan(input logic [KEY_COUNT-1:0] keys);
        int n;
        if (src_gaps_on && $urandom_range(0, 3) == 0)
        begin
            key_ch.valid <= 1'b0;
            n = gap_len();
            repeat (n) @(posedge clk);
        end
        key_ch.valid           <= 1'b1;
        key_ch.key_up_fine     <= keys[KEY_UP_FINE];
        key_ch.key_down_fine   <= keys[KEY_DOWN_FINE];
        key_ch.key_up_coarse   <= keys[KEY_UP_COARSE];
        key_ch.key_down_coarse <= keys[KEY_DOWN_COARSE];
        @(posedge clk);
        while (!key_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_readouts();
        key_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_readouts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_debounce_defaults();
        repeat (7) send_scan(4'b0001);     // press on 6th held scan, then latched
        send_scan(4'b0000);
    endtask

    task automatic test_key_order_and_limits();
        drain_readouts();
        write_reg(REG_DEBOUNCE_THRESHOLD, 10'h3F8);   // upper bits masked off
        write_reg(REG_SETPOINT_MAX, 10'd1023);
        write_reg(REG_COARSE_STEP, 10'h07F);
        write_reg(REG_NONE, 10'h3FF);
        send_scan(4'b1111);
        send_scan(4'b0000);
        send_scan(4'b0100);
        send_scan(4'b0010);
        send_scan(4'b1000);
        send_scan(4'b0000);
        send_scan(4'b1000);                // floor at zero
        send_scan(4'b0101);
        // shrink max below setpoint, zero step
        drain_readouts();
        write_reg(REG_SETPOINT_MAX, 10'd10);
        write_reg(REG_COARSE_STEP, 10'h380);
        send_scan(4'b0000);
        send_scan(4'b0001);
        send_scan(4'b0100);
    endtask

    task automatic test_never_recognized();
        drain_readouts();
        write_reg(REG_DEBOUNCE_THRESHOLD, 10'd7);
        repeat (8) send_scan(4'b0001);     // counter stops at 7, no press
    endtask

    task automatic test_backpressure();
        drain_readouts();
        src_gaps_on = 1'b0;
        sink_hold = 60;
        repeat (24) send_scan(4'($urandom_range(0, 15)));
        drain_readouts();
        src_gaps_on = 1'b1;
    endtask

    // keys held in runs of 1 to thr + 3 scans, some long enough to debounce, with some single-scan noise
    task automatic test_random_scans(input logic [THR_W-1:0] thr, input logic [SP_W-1:0] smax,
                                     input logic [STEP_W-1:0] step, input int down_pct,
                                     input int n_scans);
        logic [KEY_COUNT-1:0] lvl;
        int                   run_left [KEY_COUNT];
        int                   pct;
        int                   i;
        int                   k;
        drain_readouts();
        write_reg(REG_DEBOUNCE_THRESHOLD, {7'($urandom_range(0, 127)), thr});
        write_reg(REG_SETPOINT_MAX, smax);
        write_reg(REG_COARSE_STEP, {3'($urandom_range(0, 7)), step});
        lvl = '0;
        for (k = 0; k < KEY_COUNT; k++)
            run_left[k] = 0;
        for (i = 0; i < n_scans; i++)
        begin
            for (k = 0; k < KEY_COUNT; k++)
            begin
                if (run_left[k] == 0)
                begin
                    pct = (k == KEY_DOWN_FINE || k == KEY_DOWN_COARSE) ? down_pct : 50;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        lvl[k] = 1'($urandom_range(0, 1));
                        run_left[k] = 1;
                    end
                    else if ($urandom_range(0, 99) < pct)
                    begin
                        lvl[k] = 1'b1;
                        run_left[k] = $urandom_range(1, thr + 3);
                    end
                    else
                    begin
                        lvl[k] = 1'b0;
                        run_left[k] = $urandom_range(1, 4);
                    end
                end
                run_left[k]--;
            end
            send_scan(lvl);
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_DEBOUNCE_THRESHOLD;
        cfg_data               = '0;
        key_ch.valid           = 1'b0;
        key_ch.key_up_fine     = 1'b0;
        key_ch.key_down_fine   = 1'b0;
        key_ch.key_up_coarse   = 1'b0;
        key_ch.key_down_coarse = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_debounce_defaults();
        test_key_order_and_limits();
        test_never_recognized();
        test_backpressure();

        test_random_scans(3'd1, 10'd999, 7'd10, 50, 80);
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_scans(3'd0, 10'd1023, 7'd127, 5, 80);   // climb past 999
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        test_random_scans(3'($urandom_range(0, 7)), 10'($urandom_range(10, 60)),
                          7'($urandom_range(1, 127)), 50, 80);
        test_random_scans(3'd6, 10'($urandom_range(10, 1023)),
                          7'($urandom_range(0, 127)), 40, 80);
        test_random_scans(3'($urandom_range(0, 3)), 10'($urandom_range(10, 1023)),
                          7'($urandom_range(0, 127)), 70, 80);

        drain_readouts();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
